// ===== src/uabs_bit_encoder_unit_assert.svh =====
// Assertion macros used by the bound checker module uabs_checker.
`ifndef UABS_BIT_ENCODER_UNIT_ASSERT_SVH
`define UABS_BIT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define UABS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uabs assertion failed");

// Next-cycle implication, disabled while reset is active.
`define UABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uabs assertion failed");

`endif

// ===== src/uabs_pkg.sv =====
package uabs_pkg;

    // Probability scale and clamp limits
    localparam logic [16:0] PROB_ONE   = 17'h10000;
    localparam logic [15:0] PROB_MIN   = 16'h0001;
    localparam logic [15:0] PROB_MAX   = 16'hFFFE;
    localparam logic [31:0] STATE_INIT = 32'h0001_0000;

    // Division: 32-bit state shifted up by 16 over a 16-bit divisor
    localparam int STATE_W   = 32;
    localparam int PROB_W    = 16;
    localparam int DIVD_W    = STATE_W + PROB_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Result kinds
    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_STATE = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture input item, set up the divider
        logic step;        // one restoring division step
        logic finish;      // form t from the quotient
        logic load_word;   // place the renormalization word in the output register
        logic load_state;  // place the final coder state in the output register
        logic commit;      // write the new coder state
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic renorm;      // t reached 2^32
        logic last;        // item closes a run
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

// ===== src/uabs_bit_encoder_unit.sv =====
// uABS binary encoder. Each input transaction carries one symbol and its 16-bit
// probability of a one (clamped to 1..65534); the block divides its 32-bit coder
// state, shifted up by 16 (with p added for a one), by p or 65536 - p, and takes
// the quotient (less one for a one) as the new state; when it reaches 2^32, it
// emits the low 16 bits as a renormalization word (tuser 0) and keeps the upper
// 32 bits. On the symbol marked tlast it also emits the final 32-bit state
// (tuser 1), after which the state restarts at 65536. m_axis_tlast marks the
// last result of an input transaction. An accepted symbol is divided by a radix-2
// restoring divider, one quotient bit per cycle over 48 bits, and tready stays low
// until the symbol is through and its results are loaded, which waits while the
// output register stays full. A result waiting in the output register does not
// stop the next symbol from being accepted and divided.
module uabs_bit_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [0] bit_req, [16:1] probability, [23:17] zero
    input  logic        s_axis_tlast,   // last
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // end_of_run
);

    uabs_pkg::cmd_t    cmd;
    uabs_pkg::status_t status;

    uabs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uabs_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_bit    (s_axis_tdata[0]),
        .in_prob   (s_axis_tdata[16:1]),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_value (m_axis_tdata),
        .out_eor   (m_axis_tlast)
    );

endmodule

// ===== src/uabs_dpath.sv =====
module uabs_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  uabs_pkg::cmd_t                cmd,
    output uabs_pkg::status_t             status,
    input  logic                          in_bit,
    input  logic [uabs_pkg::PROB_W-1:0]   in_prob,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output logic [uabs_pkg::STATE_W-1:0]  out_value,
    output logic                          out_eor
);

    logic [uabs_pkg::STATE_W-1:0] state_reg;
    logic [uabs_pkg::DIVD_W-1:0]  quo_reg;
    logic [uabs_pkg::PROB_W-1:0]  rem_reg;
    logic [uabs_pkg::PROB_W-1:0]  divisor_reg;
    logic [uabs_pkg::DIVD_W-1:0]  t_reg;
    logic                         sym_reg;
    logic                         last_reg;
    logic                         out_valid_reg;
    logic                         out_kind_reg;
    logic [uabs_pkg::STATE_W-1:0] out_value_reg;
    logic                         out_eor_reg;

    logic [uabs_pkg::PROB_W-1:0]  p_clamped;
    logic [uabs_pkg::PROB_W-1:0]  divisor_next;
    logic [uabs_pkg::PROB_W:0]    rem_shift;
    logic [uabs_pkg::PROB_W:0]    rem_diff;
    logic                         q_bit;
    logic                         renorm;
    logic [uabs_pkg::STATE_W-1:0] new_state;

    // Clamp the probability so the divisor is never zero
    always_comb begin
        if (in_prob < uabs_pkg::PROB_MIN) begin
            p_clamped = uabs_pkg::PROB_MIN;
        end else if (in_prob > uabs_pkg::PROB_MAX) begin
            p_clamped = uabs_pkg::PROB_MAX;
        end else begin
            p_clamped = in_prob;
        end
    end

    // Divisor is p for a one, 65536 - p for a zero
    always_comb begin
        logic [uabs_pkg::PROB_W:0] comp;
        comp = uabs_pkg::PROB_ONE - {1'b0, p_clamped};
        divisor_next = in_bit ? p_clamped : comp[uabs_pkg::PROB_W-1:0];
    end

    // Restoring division step: shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[uabs_pkg::DIVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = (rem_shift >= {1'b0, divisor_reg});

    // Renormalize when t has any bit set at position 32 or above
    assign renorm    = |t_reg[uabs_pkg::DIVD_W-1:uabs_pkg::STATE_W];
    assign new_state = renorm ? t_reg[uabs_pkg::DIVD_W-1:uabs_pkg::PROB_W]
                              : t_reg[uabs_pkg::STATE_W-1:0];

    // Divider, t and item registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sym_reg     <= in_bit;
            last_reg    <= in_last;
            divisor_reg <= divisor_next;
            rem_reg     <= '0;
            quo_reg     <= {state_reg, (in_bit ? p_clamped : {uabs_pkg::PROB_W{1'b0}})};
        end else if (cmd.step) begin
            rem_reg <= q_bit ? rem_diff[uabs_pkg::PROB_W-1:0] : rem_shift[uabs_pkg::PROB_W-1:0];
            quo_reg <= {quo_reg[uabs_pkg::DIVD_W-2:0], q_bit};
        end
        if (cmd.finish) begin
            t_reg <= quo_reg - {{(uabs_pkg::DIVD_W-1){1'b0}}, sym_reg};
        end
    end

    // Coder state: reset to the initial state, restart after a final flush
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uabs_pkg::STATE_INIT;
        end else if (cmd.commit) begin
            state_reg <= last_reg ? uabs_pkg::STATE_INIT : new_state;
        end
    end

    // Output register: hold a result until its transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_word || cmd.load_state) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            out_kind_reg  <= uabs_pkg::KIND_WORD;
            out_value_reg <= {{(uabs_pkg::STATE_W-uabs_pkg::PROB_W){1'b0}},
                              t_reg[uabs_pkg::PROB_W-1:0]};
            out_eor_reg   <= !last_reg;
        end else if (cmd.load_state) begin
            out_kind_reg  <= uabs_pkg::KIND_STATE;
            out_value_reg <= new_state;
            out_eor_reg   <= 1'b1;
        end
    end

    assign status.renorm   = renorm;
    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_eor   = out_eor_reg;

endmodule

// ===== src/uabs_ctrl.sv =====
module uabs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  uabs_pkg::status_t status,
    output uabs_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DIVIDE,
        FINISH,
        CHECK,
        SEND_WORD,
        SEND_STATE
    } state_t;

    state_t                     state_reg, state_next;
    logic [uabs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       ready_reg, ready_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (in_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = DIVIDE;
                end
            end
            DIVIDE: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + uabs_pkg::CNT_W'(1);
                if (cnt_reg == uabs_pkg::CNT_W'(uabs_pkg::DIV_STEPS - 1)) begin
                    state_next = FINISH;
                end
            end
            FINISH: begin
                cmd.finish = 1'b1;
                state_next = CHECK;
            end
            CHECK: begin
                if (status.renorm) begin
                    state_next = SEND_WORD;
                end else if (status.last) begin
                    state_next = SEND_STATE;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            SEND_WORD: begin
                if (status.out_free) begin
                    cmd.load_word = 1'b1;
                    if (status.last) begin
                        state_next = SEND_STATE;
                    end else begin
                        cmd.commit = 1'b1;
                        state_next = IDLE;
                    end
                end
            end
            SEND_STATE: begin
                if (status.out_free) begin
                    cmd.load_state = 1'b1;
                    cmd.commit     = 1'b1;
                    state_next     = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
        ready_next = (state_next == IDLE);
    end

    // State, step counter and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

// ===== src/uabs_checker.sv =====
`include "uabs_bit_encoder_unit_assert.svh"

module uabs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result holds its data
    `UABS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A renormalization word has its upper half clear
    `UABS_ASSERT_IMPLIES(a_word_narrow, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == 1'b0), m_axis_tdata[31:16] == 16'h0000)

    // A final state always closes the run
    `UABS_ASSERT_IMPLIES(a_state_last, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // The divider is busy right after an input transaction
    `UABS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind uabs_bit_encoder_unit uabs_checker u_uabs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/uabs_encoder_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the uABS encoder, predicts the result transactions
// of every accepted symbol and compares them in order against the block output.
module uabs_encoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [0] bit_req, [16:1] probability, [23:17] zero
    input  logic        s_axis_tlast,   // last
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] value
    input  logic        m_axis_tuser,   // [0] kind
    input  logic        m_axis_tlast,   // end_of_run
    output int          fail_count,
    output int          pending,
    output int          n_symbols,
    output int          n_words,
    output int          n_states
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        end_of_run;
    } enc_result_t;

    enc_result_t expected_q[$];
    enc_result_t exp_r;
    logic [31:0] coder_state;
    int          n_fail = 0;

    initial begin
        pending    = 0;
        n_symbols  = 0;
        n_words    = 0;
        n_states   = 0;
    end

    assign fail_count = n_fail;

    // Print one line per mismatch, stay quiet after the cap but keep counting
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_fail < PRINT_CAP)
            $display("%0t mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got,
                     want);
        n_fail++;
    endtask

    // Encode one symbol into the coder state and queue the results it causes
    task automatic encode_symbol(input logic sym, input logic [15:0] prob, input logic fin);
        logic [15:0] p;
        logic [63:0] divd;
        logic [63:0] divs;
        logic [63:0] t;
        p = prob;
        if (p == 16'd0)
            p = uabs_pkg::PROB_MIN;
        else if (p > uabs_pkg::PROB_MAX)
            p = uabs_pkg::PROB_MAX;
        divd = {16'h0, coder_state, 16'h0};
        if (sym) begin
            divs = {48'h0, p};
            t = (divd | divs) / divs - 64'd1;
        end else begin
            divs = {47'h0, uabs_pkg::PROB_ONE} - {48'h0, p};
            t = divd / divs;
        end
        if (t[63:32] != 32'd0) begin
            expected_q.push_back('{kind: uabs_pkg::KIND_WORD, value: {16'h0, t[15:0]},
                                   end_of_run: !fin});
            t = t >> 16;
        end
        coder_state = t[31:0];
        if (fin) begin
            expected_q.push_back('{kind: uabs_pkg::KIND_STATE, value: coder_state,
                                   end_of_run: 1'b1});
            coder_state = uabs_pkg::STATE_INIT;
        end
    endtask

    // Check the output transaction first, then predict from the input transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            coder_state = uabs_pkg::STATE_INIT;
            expected_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (m_axis_tuser == uabs_pkg::KIND_STATE)
                    n_states <= n_states + 1;
                else
                    n_words <= n_words + 1;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 32'd0);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_axis_tuser !== exp_r.kind)
                        report_mismatch("kind", {31'd0, m_axis_tuser}, {31'd0, exp_r.kind});
                    if (m_axis_tdata !== exp_r.value)
                        report_mismatch("value", m_axis_tdata, exp_r.value);
                    if (m_axis_tlast !== exp_r.end_of_run)
                        report_mismatch("end_of_run", {31'd0, m_axis_tlast},
                                        {31'd0, exp_r.end_of_run});
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                encode_symbol(s_axis_tdata[0], s_axis_tdata[16:1], s_axis_tlast);
                n_symbols <= n_symbols + 1;
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Drives symbol runs into the uABS encoder with bursty input and a stalling
// receiver; the checker beside the block does all prediction and comparison.
module tb;

    localparam int N_RANDOM     = 1250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int n_symbols;
    int n_words;
    int n_states;
    int burst_left = 4;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;

    uabs_bit_encoder_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    uabs_encoder_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_symbols     (n_symbols),
        .n_words       (n_words),
        .n_states      (n_states)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: change stall mode now and then, honor one long hold-off
    initial begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       hold_left;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ((mode_left % 16) < 10);
                endcase
            end
        end
    end

    // Pick a probability with extra weight on the clamp limits and the edges
    function automatic logic [15:0] pick_prob();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return uabs_pkg::PROB_MIN;
            3:       return uabs_pkg::PROB_MAX;
            4:       return 16'($urandom_range(1, 255));
            5:       return 16'(16'hFFFF - $urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one symbol, hold until accepted, then idle if the burst is over
    task automatic send_symbol(input logic sym, input logic [15:0] prob, input logic fin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, prob, sym};
        s_axis_tlast  <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 70)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int run_left;
        run_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: clamp limits, renorm boundary, renorm together with last
        send_symbol(1'b0, 16'h0000, 1'b0);
        send_symbol(1'b1, 16'h0000, 1'b0);
        send_symbol(1'b1, 16'hFFFF, 1'b1);
        send_symbol(1'b0, uabs_pkg::PROB_MAX, 1'b0);
        send_symbol(1'b0, uabs_pkg::PROB_MAX, 1'b0);
        send_symbol(1'b0, 16'hFFFF, 1'b1);
        send_symbol(1'b1, uabs_pkg::PROB_MIN, 1'b1);
        send_symbol(1'b0, 16'h8000, 1'b1);
        send_symbol(1'b1, 16'h8000, 1'b0);
        send_symbol(1'b0, uabs_pkg::PROB_MIN, 1'b0);
        send_symbol(1'b1, uabs_pkg::PROB_MAX, 1'b0);
        send_symbol(1'b0, 16'hAAAA, 1'b0);
        send_symbol(1'b1, 16'h5555, 1'b1);
        send_symbol(1'b1, 16'h0000, 1'b0);
        send_symbol(1'b1, 16'h0000, 1'b0);
        send_symbol(1'b0, 16'hFFFF, 1'b1);
        drain();

        // Random runs of symbols, each closed by last
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 4)
                hold_req = 1'b1;
            if (i == N_RANDOM / 2)
                drain();
            if (run_left == 0)
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                       : $urandom_range(1, 12);
            run_left--;
            send_symbol(1'($urandom_range(0, 1)), pick_prob(),
                        (run_left == 0) || (i == N_RANDOM - 1));
        end
        drain();

        $display("Encoded %0d symbols over %0d runs under bursty input and receiver stalls;",
                 n_symbols, n_states);
        $display("checked %0d renormalization words and %0d final states.", n_words, n_states);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
